// File: rtl/owm_pkg.sv
`default_nettype none
package owm_pkg;

	localparam int TIMER_BITS = 10;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam int QDEPTH = 2;

	localparam logic [2:0] REG_RESET_LOW    = 3'd0;
	localparam logic [2:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [2:0] REG_PRES_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_REL_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_START_LOW    = 3'd4;
	localparam logic [2:0] REG_SAMPLE_DLY   = 3'd5;
	localparam logic [2:0] REG_SLOT_TIME    = 3'd6;

	localparam logic [7:0] ROM_SKIP     = 8'hCC;
	localparam logic [7:0] CONVERT_T    = 8'h44;
	localparam logic [7:0] READ_SCRATCH = 8'hBE;
	localparam logic [7:0] CONV_DONE    = 8'hFF;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_RESET = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_TEMP  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_GAP  = 4'd2,
		PH_PRES_LOW = 4'd3,
		PH_PRES_REL = 4'd4,
		PH_W_START  = 4'd5,
		PH_W_HOLD   = 4'd6,
		PH_R_START  = 4'd7,
		PH_R_WAIT   = 4'd8,
		PH_R_REC    = 4'd9
	} phase_t;

	typedef enum logic [3:0] {
		SQ_NONE    = 4'd0,
		SQ_RESET1  = 4'd1,
		SQ_SKIP1   = 4'd2,
		SQ_CONVERT = 4'd3,
		SQ_POLL    = 4'd4,
		SQ_RESET2  = 4'd5,
		SQ_SKIP2   = 4'd6,
		SQ_READ_SP = 4'd7,
		SQ_LOW     = 4'd8,
		SQ_HIGH    = 4'd9
	} seq_t;

	typedef enum logic [1:0] {
		OP_RESET = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [5:0] presence_wait;
		logic [7:0] presence_timeout;
		logic [7:0] release_timeout;
		logic [3:0] start_low_time;
		logic [4:0] sample_delay;
		logic [6:0] slot_time;
	} cfg_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] data_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		phase_t     ph;
		logic [7:0] sh;
	} start_t;

	function automatic start_t op_start(op_t op, logic [7:0] b);
		start_t s;
		case (op)
			OP_RESET: s = '{ph: PH_RST_LOW, sh: 8'd0};
			OP_WRITE: s = '{ph: PH_W_START, sh: b};
			OP_READ:  s = '{ph: PH_R_START, sh: 8'd0};
			default:  s = '{ph: PH_IDLE, sh: 8'd0};
		endcase
		return s;
	endfunction

	// zero counts as one tick, anything past the timer counts as its maximum
	function automatic logic [TIMER_BITS-1:0] clamp_dur(logic [15:0] v);
		logic [15:0] r;
		r = v;
		if (r == 16'd0) r = 16'd1;
		if (r > 16'(TMAX)) r = 16'(TMAX);
		return r[TIMER_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/one_wire_master_temp_read.sv
// One-wire bus master, one input transfer per microsecond tick. Each tick carries a
// command and the sampled bus level and yields exactly one result transfer with the
// drive-low decision for that microsecond plus busy, done, last byte read, temperature
// word and presence error. Throughput is one tick per clock while the output side does
// not stall: the tick engine computes its whole next state combinationally. A two-entry
// input queue feeds the engine and the result sits in an output register, so a tick
// passes through the queue and then the output register, and waits longer when the output
// side stalls. The user writes timing registers over APB only while the block is idle; the block does not enforce it.
`default_nettype none
module one_wire_master_temp_read import owm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // command[2:0], data_byte[10:3], line_level[11]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // drive_low[0], busy_res[1], done_res[2],
	                                   // read_value[10:3], temperature[26:11],
	                                   // presence_error[27]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t  cfg_q;
	logic  item_valid;
	logic  item_ready;
	item_t item;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time   <= 10'd750;
			cfg_q.presence_wait    <= 6'd15;
			cfg_q.presence_timeout <= 8'd200;
			cfg_q.release_timeout  <= 8'd240;
			cfg_q.start_low_time   <= 4'd2;
			cfg_q.sample_delay     <= 5'd8;
			cfg_q.slot_time        <= 7'd60;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_RESET_LOW:    cfg_q.reset_low_time   <= pwdata[9:0];
				REG_PRES_WAIT:    cfg_q.presence_wait    <= pwdata[5:0];
				REG_PRES_TIMEOUT: cfg_q.presence_timeout <= pwdata[7:0];
				REG_REL_TIMEOUT:  cfg_q.release_timeout  <= pwdata[7:0];
				REG_START_LOW:    cfg_q.start_low_time   <= pwdata[3:0];
				REG_SAMPLE_DLY:   cfg_q.sample_delay     <= pwdata[4:0];
				REG_SLOT_TIME:    cfg_q.slot_time        <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_RESET_LOW:    prdata = 32'(cfg_q.reset_low_time);
			REG_PRES_WAIT:    prdata = 32'(cfg_q.presence_wait);
			REG_PRES_TIMEOUT: prdata = 32'(cfg_q.presence_timeout);
			REG_REL_TIMEOUT:  prdata = 32'(cfg_q.release_timeout);
			REG_START_LOW:    prdata = 32'(cfg_q.start_low_time);
			REG_SAMPLE_DLY:   prdata = 32'(cfg_q.sample_delay);
			REG_SLOT_TIME:    prdata = 32'(cfg_q.slot_time);
			default:          prdata = 32'd0;
		endcase
	end

	owm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	owm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/owm_front.sv
`default_nettype none
module owm_front import owm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,
	output logic             item_valid,
	input  wire logic        item_ready,
	output item_t            item
);

	item_t      queue_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       kind;

	// codes five to seven act as tick only
	always_comb begin
		case (s_tdata[2:0])
			CMD_RESET: kind = CMD_RESET;
			CMD_WRITE: kind = CMD_WRITE;
			CMD_READ:  kind = CMD_READ;
			CMD_TEMP:  kind = CMD_TEMP;
			default:   kind = CMD_TICK;
		endcase
	end

	assign s_tready   = (count_q != 2'(QDEPTH));
	assign push       = s_tvalid && s_tready;
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_valid && item_ready;
	assign item       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: kind, data_byte: s_tdata[10:3], line_level: s_tdata[11]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/owm_engine.sv
`default_nettype none
module owm_engine import owm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata
);

	phase_t                phase_q, n_phase;
	logic [TIMER_BITS-1:0] tc_q, n_tc;
	logic [2:0]            bit_q, n_bit;
	logic [7:0]            shift_q, n_shift;
	seq_t                  seq_q, n_seq;
	logic [7:0]            low_q, n_low;
	logic [15:0]           temp_q, n_temp;
	logic                  err_q, n_err;
	logic [7:0]            last_q, n_last;
	logic                  drive;
	logic                  done;
	logic                  sub_end;
	logic [TIMER_BITS-1:0] dur;
	logic [TIMER_BITS-1:0] tc_sat;
	logic [TIMER_BITS-1:0] tick_tc;
	logic                  elapsed;
	logic                  step;
	logic                  tvalid_q;
	logic [31:0]           tdata_q;
	start_t                st;

	assign item_ready = !tvalid_q || m_tready;
	assign step       = item_valid && item_ready;
	assign m_tvalid   = tvalid_q;
	assign m_tdata    = tdata_q;

	always_comb begin
		n_phase = phase_q;
		n_tc    = tc_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_seq   = seq_q;
		n_low   = low_q;
		n_temp  = temp_q;
		n_err   = err_q;
		n_last  = last_q;
		drive   = 1'b0;
		done    = 1'b0;
		sub_end = 1'b0;
		st      = '{ph: PH_IDLE, sh: 8'd0};

		if (n_phase == PH_IDLE) begin
			case (item.kind)
				CMD_RESET: begin
					n_seq = SQ_NONE;
					st    = op_start(OP_RESET, 8'd0);
				end
				CMD_WRITE: begin
					n_seq = SQ_NONE;
					st    = op_start(OP_WRITE, item.data_byte);
				end
				CMD_READ: begin
					n_seq = SQ_NONE;
					st    = op_start(OP_READ, 8'd0);
				end
				CMD_TEMP: begin
					n_seq = SQ_RESET1;
					st    = op_start(OP_RESET, 8'd0);
				end
				default: st = '{ph: PH_IDLE, sh: shift_q};
			endcase
			if (st.ph != PH_IDLE) begin
				n_phase = st.ph;
				n_shift = st.sh;
				n_tc    = '0;
				n_bit   = 3'd0;
			end
		end

		case (n_phase)
			PH_RST_LOW:  dur = clamp_dur(16'(cfg.reset_low_time));
			PH_RST_GAP:  dur = clamp_dur(16'(cfg.presence_wait));
			PH_PRES_LOW: dur = clamp_dur(16'(cfg.presence_timeout));
			PH_PRES_REL: dur = clamp_dur(16'(cfg.release_timeout));
			PH_W_START,
			PH_R_START:  dur = clamp_dur(16'(cfg.start_low_time));
			PH_R_WAIT:   dur = clamp_dur(16'(cfg.sample_delay));
			default:     dur = clamp_dur(16'(cfg.slot_time));
		endcase
		tc_sat  = (n_tc < TMAX) ? n_tc + 1'b1 : n_tc;
		elapsed = (tc_sat >= dur);
		tick_tc = elapsed ? '0 : tc_sat;

		case (n_phase)
			PH_RST_LOW: begin
				drive = 1'b1;
				n_tc  = tick_tc;
				if (elapsed) n_phase = PH_RST_GAP;
			end
			PH_RST_GAP: begin
				n_tc = tick_tc;
				if (elapsed) n_phase = PH_PRES_LOW;
			end
			PH_PRES_LOW: begin
				if (!item.line_level) begin
					n_tc    = '0;
					n_phase = PH_PRES_REL;
				end else begin
					n_tc = tick_tc;
					if (elapsed) begin
						n_err   = 1'b1;
						sub_end = 1'b1;
					end
				end
			end
			PH_PRES_REL: begin
				if (item.line_level) begin
					n_err   = 1'b0;
					sub_end = 1'b1;
				end else begin
					n_tc = tick_tc;
					if (elapsed) begin
						n_err   = 1'b1;
						sub_end = 1'b1;
					end
				end
			end
			PH_W_START: begin
				drive = 1'b1;
				n_tc  = tick_tc;
				if (elapsed) n_phase = PH_W_HOLD;
			end
			PH_W_HOLD: begin
				drive = !n_shift[0];
				n_tc  = tick_tc;
				if (elapsed) begin
					n_shift = {1'b0, n_shift[7:1]};
					if (n_bit == 3'd7) begin
						sub_end = 1'b1;
					end else begin
						n_bit   = n_bit + 3'd1;
						n_phase = PH_W_START;
					end
				end
			end
			PH_R_START: begin
				drive = 1'b1;
				n_tc  = tick_tc;
				if (elapsed) n_phase = PH_R_WAIT;
			end
			PH_R_WAIT: begin
				n_tc = tick_tc;
				if (elapsed) n_phase = PH_R_REC;
			end
			PH_R_REC: begin
				if (n_tc == '0) n_shift = {item.line_level, n_shift[7:1]};
				n_tc = tick_tc;
				if (elapsed) begin
					if (n_bit == 3'd7) begin
						n_last  = n_shift;
						sub_end = 1'b1;
					end else begin
						n_bit   = n_bit + 3'd1;
						n_phase = PH_R_START;
					end
				end
			end
			default: n_phase = PH_IDLE;
		endcase

		// end of a sub-operation: chain the next step of the temperature sequence, or finish
		if (sub_end) begin
			n_phase = PH_IDLE;
			n_tc    = '0;
			st      = '{ph: PH_IDLE, sh: 8'd0};
			case (n_seq)
				SQ_RESET1: begin
					n_seq = SQ_SKIP1;
					st    = op_start(OP_WRITE, ROM_SKIP);
				end
				SQ_SKIP1: begin
					n_seq = SQ_CONVERT;
					st    = op_start(OP_WRITE, CONVERT_T);
				end
				SQ_CONVERT: begin
					n_seq = SQ_POLL;
					st    = op_start(OP_READ, 8'd0);
				end
				SQ_POLL: begin
					if (n_last == CONV_DONE) begin
						n_seq = SQ_RESET2;
						st    = op_start(OP_RESET, 8'd0);
					end else begin
						st = op_start(OP_READ, 8'd0);
					end
				end
				SQ_RESET2: begin
					n_seq = SQ_SKIP2;
					st    = op_start(OP_WRITE, ROM_SKIP);
				end
				SQ_SKIP2: begin
					n_seq = SQ_READ_SP;
					st    = op_start(OP_WRITE, READ_SCRATCH);
				end
				SQ_READ_SP: begin
					n_seq = SQ_LOW;
					st    = op_start(OP_READ, 8'd0);
				end
				SQ_LOW: begin
					n_low = n_last;
					n_seq = SQ_HIGH;
					st    = op_start(OP_READ, 8'd0);
				end
				SQ_HIGH: begin
					n_temp = {n_last, n_low};
					n_seq  = SQ_NONE;
					done   = 1'b1;
				end
				default: begin
					n_seq = SQ_NONE;
					done  = 1'b1;
				end
			endcase
			if (st.ph != PH_IDLE) begin
				n_phase = st.ph;
				n_shift = st.sh;
				n_bit   = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tc_q     <= '0;
			bit_q    <= 3'd0;
			shift_q  <= 8'd0;
			seq_q    <= SQ_NONE;
			low_q    <= 8'd0;
			temp_q   <= 16'd0;
			err_q    <= 1'b0;
			last_q   <= 8'd0;
			tvalid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= n_phase;
				tc_q    <= n_tc;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				seq_q   <= n_seq;
				low_q   <= n_low;
				temp_q  <= n_temp;
				err_q   <= n_err;
				last_q  <= n_last;
			end
			if (item_ready) tvalid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			tdata_q <= {4'd0, n_err, n_temp, n_last, done, (n_phase != PH_IDLE), drive};
		end
	end

endmodule
`default_nettype wire

// File: rtl/owm_checker.sv
`default_nettype none
module owm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// a finished operation leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1])
		else $error("done with busy set");

	// bus is released when nothing runs or finishes
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] && !m_tdata[2] |-> !m_tdata[0])
		else $error("bus driven while idle");

	// an empty output stage accepts the next tick
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && $past(!m_tvalid) && $past(!s_tvalid) |-> s_tready)
		else $error("input stalled with empty pipeline");

endmodule

bind one_wire_master_temp_read owm_checker u_owm_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import owm_pkg::*;

	localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
	localparam int REG_WIDTH [7] = '{10, 6, 8, 8, 4, 5, 7};

	typedef struct packed {
		logic        drive;
		logic        busy;
		logic        done;
		logic [7:0]  rd;
		logic [15:0] temp;
		logic        perr;
	} tick_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	one_wire_master_temp_read u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bus master state as predicted
	int unsigned tmr_cfg [7] = '{750, 15, 200, 240, 2, 8, 60};
	phase_t      m_ph = PH_IDLE;
	int unsigned m_cnt = 0;
	logic [2:0]  m_bit = '0;
	logic [7:0]  m_shift = '0;
	seq_t        m_seq = SQ_NONE;
	logic [7:0]  m_low = '0;
	logic [15:0] m_temp = '0;
	logic        m_err = 1'b0;
	logic [7:0]  m_last = '0;

	// slave device behavior
	bit          dev_present = 1'b1;
	bit          dev_stuck = 1'b0;
	int          dev_polls = 0;
	int          dev_noise = 0;
	logic [7:0]  dev_byte = '0;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          busy_cmd_pct = 0;

	tick_res_t   expected_ticks [$];
	int          n_fail = 0;
	int          n_items = 0;
	int          n_checked = 0;
	int          n_done = 0;
	int          n_temp = 0;
	int          n_pres_err = 0;

	function automatic void op_begin(op_t k, logic [7:0] b);
		m_cnt = 0;
		m_bit = 3'd0;
		case (k)
			OP_RESET: begin
				m_ph = PH_RST_LOW;
				m_shift = '0;
			end
			OP_WRITE: begin
				m_ph = PH_W_START;
				m_shift = b;
			end
			default: begin
				m_ph = PH_R_START;
				m_shift = '0;
			end
		endcase
	endfunction

	function automatic bit elapsed(logic [2:0] r);
		int unsigned d;
		d = tmr_cfg[r];
		if (d == 0) d = 1;
		if (d > TMAX) d = 32'(TMAX);
		if (m_cnt < TMAX) m_cnt++;
		if (m_cnt >= d) begin
			m_cnt = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// end of one bus operation; chains the temperature sequence
	function automatic bit step_done();
		m_ph = PH_IDLE;
		m_cnt = 0;
		case (m_seq)
			SQ_RESET1: begin
				m_seq = SQ_SKIP1;
				op_begin(OP_WRITE, ROM_SKIP);
			end
			SQ_SKIP1: begin
				m_seq = SQ_CONVERT;
				op_begin(OP_WRITE, CONVERT_T);
			end
			SQ_CONVERT: begin
				m_seq = SQ_POLL;
				op_begin(OP_READ, 8'h00);
			end
			SQ_POLL: begin
				if (m_last == CONV_DONE) begin
					m_seq = SQ_RESET2;
					op_begin(OP_RESET, 8'h00);
				end else begin
					op_begin(OP_READ, 8'h00);
				end
			end
			SQ_RESET2: begin
				m_seq = SQ_SKIP2;
				op_begin(OP_WRITE, ROM_SKIP);
			end
			SQ_SKIP2: begin
				m_seq = SQ_READ_SP;
				op_begin(OP_WRITE, READ_SCRATCH);
			end
			SQ_READ_SP: begin
				m_seq = SQ_LOW;
				op_begin(OP_READ, 8'h00);
			end
			SQ_LOW: begin
				m_low = m_last;
				m_seq = SQ_HIGH;
				op_begin(OP_READ, 8'h00);
			end
			SQ_HIGH: begin
				m_temp = {m_last, m_low};
				m_seq = SQ_NONE;
				n_temp++;
				return 1'b1;
			end
			default: begin
				m_seq = SQ_NONE;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic tick_res_t predict_tick(logic [2:0] c, logic [7:0] d, logic lvl);
		tick_res_t r;
		logic      drv;
		bit        fin;
		drv = 1'b0;
		fin = 1'b0;
		if (m_ph == PH_IDLE) begin
			case (c)
				CMD_RESET: begin
					m_seq = SQ_NONE;
					op_begin(OP_RESET, d);
				end
				CMD_WRITE: begin
					m_seq = SQ_NONE;
					op_begin(OP_WRITE, d);
				end
				CMD_READ: begin
					m_seq = SQ_NONE;
					op_begin(OP_READ, d);
				end
				CMD_TEMP: begin
					m_seq = SQ_RESET1;
					op_begin(OP_RESET, d);
				end
				default: ;
			endcase
		end
		case (m_ph)
			PH_RST_LOW: begin
				drv = 1'b1;
				if (elapsed(REG_RESET_LOW)) m_ph = PH_RST_GAP;
			end
			PH_RST_GAP: begin
				if (elapsed(REG_PRES_WAIT)) m_ph = PH_PRES_LOW;
			end
			PH_PRES_LOW: begin
				if (!lvl) begin
					m_cnt = 0;
					m_ph = PH_PRES_REL;
				end else if (elapsed(REG_PRES_TIMEOUT)) begin
					m_err = 1'b1;
					n_pres_err++;
					fin = step_done();
				end
			end
			PH_PRES_REL: begin
				if (lvl) begin
					m_err = 1'b0;
					fin = step_done();
				end else if (elapsed(REG_REL_TIMEOUT)) begin
					m_err = 1'b1;
					n_pres_err++;
					fin = step_done();
				end
			end
			PH_W_START: begin
				drv = 1'b1;
				if (elapsed(REG_START_LOW)) m_ph = PH_W_HOLD;
			end
			PH_W_HOLD: begin
				drv = !m_shift[0];
				if (elapsed(REG_SLOT_TIME)) begin
					m_shift = m_shift >> 1;
					if (m_bit >= 7) begin
						fin = step_done();
					end else begin
						m_bit++;
						m_ph = PH_W_START;
					end
				end
			end
			PH_R_START: begin
				drv = 1'b1;
				if (elapsed(REG_START_LOW)) m_ph = PH_R_WAIT;
			end
			PH_R_WAIT: begin
				if (elapsed(REG_SAMPLE_DLY)) m_ph = PH_R_REC;
			end
			PH_R_REC: begin
				if (m_cnt == 0) m_shift = {lvl, m_shift[7:1]};
				if (elapsed(REG_SLOT_TIME)) begin
					if (m_bit >= 7) begin
						m_last = m_shift;
						fin = step_done();
					end else begin
						m_bit++;
						m_ph = PH_R_START;
					end
				end
			end
			default: m_ph = PH_IDLE;
		endcase
		if (fin) n_done++;
		r.drive = drv;
		r.busy = (m_ph != PH_IDLE);
		r.done = fin;
		r.rd = m_last;
		r.temp = m_temp;
		r.perr = m_err;
		return r;
	endfunction

	// bus level the slave would show on the coming tick
	function automatic logic pick_level();
		if ($urandom_range(0, 99) < dev_noise) return 1'($urandom_range(0, 1));
		case (m_ph)
			PH_PRES_LOW: return !(dev_present && $urandom_range(0, 2) == 0);
			PH_PRES_REL: return !dev_stuck && $urandom_range(0, 2) == 0;
			PH_R_REC: begin
				if (m_cnt == 0) begin
					if (m_bit == 3'd0) begin
						if (m_seq != SQ_POLL) begin
							dev_byte = 8'($urandom);
						end else if (dev_polls > 0) begin
							dev_polls--;
							dev_byte = 8'($urandom_range(0, 254));
						end else begin
							dev_byte = CONV_DONE;
						end
					end
					return dev_byte[m_bit];
				end
			end
			default: ;
		endcase
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic void check_field(string f, int unsigned e, int unsigned a);
		if (e != a) begin
			n_fail++;
			if (n_fail <= 10)
				$display("%0t mismatch %s: expected %0h got %0h", $realtime, f, e, a);
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_results
		tick_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ticks.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("%0t result transfer with nothing pending: %0h", $realtime, m_tdata);
			end else begin
				e = expected_ticks.pop_front();
				n_checked++;
				check_field("drive_low", 32'(e.drive), 32'(m_tdata[0]));
				check_field("busy", 32'(e.busy), 32'(m_tdata[1]));
				check_field("done", 32'(e.done), 32'(m_tdata[2]));
				check_field("read_value", 32'(e.rd), 32'(m_tdata[10:3]));
				check_field("temperature", 32'(e.temp), 32'(m_tdata[26:11]));
				check_field("presence_error", 32'(e.perr), 32'(m_tdata[27]));
			end
		end
	end

	task automatic send_tick(logic [2:0] c, logic [7:0] d, logic lvl);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, lvl, d, c};
		do @(posedge clk); while (!s_tready);
		expected_ticks.push_back(predict_tick(c, d, lvl));
		n_items++;
	endtask

	task automatic run_op(logic [2:0] c, logic [7:0] d);
		logic [2:0] nc;
		send_tick(c, d, pick_level());
		while (m_ph != PH_IDLE) begin
			nc = CMD_TICK;
			if ($urandom_range(0, 99) < busy_cmd_pct) nc = 3'($urandom_range(0, 7));
			send_tick(nc, 8'($urandom), pick_level());
		end
	endtask

	task automatic settle();
		while (m_ph != PH_IDLE) send_tick(CMD_TICK, 8'($urandom), pick_level());
		s_tvalid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
	endtask

	task automatic reg_read(logic [2:0] idx, output logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] v);
		logic [31:0] rb;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tmr_cfg[idx] = v & ((32'd1 << REG_WIDTH[idx]) - 1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_read(idx, rb);
		check_field("register readback", tmr_cfg[idx], rb);
	endtask

	task automatic load_timing(input int unsigned v [7]);
		settle();
		for (int i = 0; i < 7; i++) set_reg(3'(i), v[3'(i)]);
	endtask

	task automatic set_pacing(int s, int r);
		send_idle_pct = s;
		recv_stall_pct = r;
	endtask

	task automatic test_default_timing();
		logic [31:0] rb;
		set_pacing(0, 0);
		for (int i = 0; i < 7; i++) begin
			reg_read(3'(i), rb);
			check_field("register after reset", tmr_cfg[3'(i)], rb);
		end
		dev_present = 1'b1;
		dev_stuck = 1'b0;
		run_op(CMD_TICK, 8'h00);
	endtask

	// zero in every register counts as a single tick
	task automatic test_one_tick_timing();
		set_pacing(9, 9);
		load_timing('{0, 0, 0, 0, 0, 0, 0});
		run_op(CMD_TICK, 8'hFF);
		run_op(CMD_RESET, 8'h00);
		run_op(CMD_WRITE, 8'hA5);
		run_op(CMD_READ, 8'h00);
		dev_present = 1'b0;
		run_op(CMD_RESET, 8'h00);
		dev_present = 1'b1;
		dev_stuck = 1'b1;
		run_op(CMD_RESET, 8'h00);
		dev_stuck = 1'b0;
		for (int k = 0; k < 3; k++) run_op(3'(CMD_BAD_FIRST + k), 8'($urandom));
		busy_cmd_pct = 100;
		run_op(CMD_WRITE, 8'h5A);
		run_op(CMD_READ, 8'h00);
		busy_cmd_pct = 0;
	endtask

	task automatic test_temperature_sequence();
		set_pacing(9, 9);
		load_timing('{2, 1, 3, 3, 1, 1, 2});
		dev_polls = 2;
		run_op(CMD_TEMP, 8'h00);
		// no device: presence errors are recorded and the sequence carries on
		dev_present = 1'b0;
		dev_polls = 0;
		run_op(CMD_TEMP, 8'h00);
		dev_present = 1'b1;
	endtask

	// all-ones writes read back cut to each register's width
	task automatic test_max_timing();
		set_pacing(9, 9);
		load_timing('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		run_op(CMD_TICK, 8'h69);
	endtask

	task automatic test_random_traffic();
		int          s_pct [4] = '{0, 50, 0, 9};
		int          r_pct [4] = '{0, 0, 50, 9};
		int unsigned v [7];
		int          first;
		logic [2:0]  c;
		for (int p = 0; p < 4; p++) begin
			v[REG_RESET_LOW] = $urandom_range(1, 6);
			v[REG_PRES_WAIT] = $urandom_range(0, 3);
			v[REG_PRES_TIMEOUT] = $urandom_range(1, 6);
			v[REG_REL_TIMEOUT] = $urandom_range(1, 6);
			v[REG_START_LOW] = $urandom_range(1, 3);
			v[REG_SAMPLE_DLY] = $urandom_range(1, 3);
			v[REG_SLOT_TIME] = $urandom_range(1, 3);
			load_timing(v);
			set_pacing(s_pct[2'(p)], r_pct[2'(p)]);
			busy_cmd_pct = 20;
			first = n_items;
			while (n_items - first < 120) begin
				case ($urandom_range(0, 19))
					0, 1:          c = CMD_TICK;
					2, 3, 4:       c = CMD_RESET;
					5, 6, 7, 8, 9: c = CMD_WRITE;
					10, 11, 12, 13, 14: c = CMD_READ;
					15, 16, 17:    c = CMD_TEMP;
					default:       c = 3'(CMD_BAD_FIRST + $urandom_range(0, 2));
				endcase
				dev_present = ($urandom_range(0, 9) != 0);
				dev_stuck = ($urandom_range(0, 9) == 0);
				dev_polls = $urandom_range(0, 2);
				dev_noise = ($urandom_range(0, 9) == 0) ? 15 : 0;
				run_op(c, 8'($urandom));
			end
			dev_noise = 0;
			busy_cmd_pct = 0;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_timing();
		test_one_tick_timing();
		test_temperature_sequence();
		test_max_timing();
		test_random_traffic();
		s_tvalid <= 1'b0;
		for (int k = 0; k < 2000 && expected_ticks.size() != 0; k++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_ticks.size() != 0) begin
			$display("%0d expected results never arrived", expected_ticks.size());
			n_fail += expected_ticks.size();
		end
		$display("%0d ticks sent, %0d results checked, %0d operations completed",
			n_items, n_checked, n_done);
		$display("%0d temperature words read, %0d presence timeouts, %0d failures",
			n_temp, n_pres_err, n_fail);
		if (n_fail == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
